[src/pidv_pkg.sv]
// Shared constants for the variable-step PID controller.
package pidv_pkg;

    // Gain and configuration port widths
    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int DRIVE_W    = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 4'd3;

    // Reset values of the registers
    localparam logic signed [GAIN_W-1:0]     GAIN_P_RST = 16'sd2048;
    localparam logic signed [GAIN_W-1:0]     GAIN_I_RST = 16'sd41;
    localparam logic signed [GAIN_W-1:0]     GAIN_D_RST = 16'sd819;
    localparam logic signed [CFG_DATA_W-1:0] TARGET_RST = 16'sd2560;

    // Fixed-point alignment
    localparam int DERIV_SHIFT = 20;  // derivative numerator scale
    localparam int P_SHIFT     = 12;  // P term to Q.32
    localparam int D_SHIFT     = 4;   // D term to Q.32
    localparam int OUT_SHIFT   = 16;  // Q.32 sum to Q16.16 drive

endpackage

[src/pidv_sample_if.sv]
// Input sample channel: measurement and time step.
interface pidv_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic        [SAMPLE_WIDTH-1:0] step_time;

    modport source (output valid, output measured, output step_time, input ready);
    modport sink   (input valid, input measured, input step_time, output ready);
endinterface

[src/pidv_result_if.sv]
// Result channel: drive value and status flags.
interface pidv_result_if;
    import pidv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clipped;
    logic                      zero_step;

    modport source (output valid, output drive, output clipped, output zero_step, input ready);
    modport sink   (input valid, input drive, input clipped, input zero_step, output ready);
endinterface

[src/pidv_cfg_if.sv]
// Configuration write channel: register index and data.
interface pidv_cfg_if;
    import pidv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/pid_controller_variable_dt.sv]
// Positional PID controller with variable time step, bit-serial datapath.
//
// Each sample beat carries a signed Q8.8 measurement and an unsigned Q4.12
// time step. The block forms error = target - measured, adds error*step_time
// into a saturating ACCUM_WIDTH-bit integral (Q.20), divides the error
// difference (scaled by 2^20) by step_time for the derivative, and returns
// gain_p*e + gain_i*I + gain_d*D rounded half up and saturated to signed
// Q16.16. A zero step_time forces the derivative to 0 and sets zero_step;
// clipped flags integral or output saturation. One result beat per sample.
// Datapath: every product is formed by a shift-add unit that consumes one bit
// of the multiplier per cycle (step_time for the integral, then each gain).
// A restoring divider running one quotient bit per cycle works in parallel
// with the multiplies. A new sample is taken only after the last one has
// left ST_ROUND, which holds while the output register is still full. The
// finished result sits in an output register, so a new sample is taken
// while it waits. Configuration beats are accepted every cycle and must only
// arrive while the block is idle.
module pid_controller_variable_dt #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCUM_WIDTH  = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pidv_sample_if.sink          sample,
    pidv_result_if.source        result,
    pidv_cfg_if.sink             cfg
);
    import pidv_pkg::*;

    // Datapath widths
    localparam int SW      = SAMPLE_WIDTH;
    localparam int AW      = ACCUM_WIDTH;
    localparam int ERR_W   = SW + 1;             // target - measured
    localparam int DIFF_W  = SW + 2;             // error - last error
    localparam int PROD_W  = ERR_W + SW;         // error * step_time
    localparam int DIV_W   = DIFF_W + DERIV_SHIFT;
    localparam int DERIV_W = DIV_W + 1;
    localparam int T_P     = GAIN_W + ERR_W + P_SHIFT + 1;
    localparam int T_I     = GAIN_W + AW;
    localparam int T_D     = GAIN_W + DERIV_W + D_SHIFT;
    localparam int T_PI    = (T_P > T_I) ? T_P : T_I;
    localparam int SUM_W   = ((T_PI > T_D) ? T_PI : T_D) + 2;
    localparam int ADD_W   = ((AW > PROD_W) ? AW : PROD_W) + 1;
    localparam int RND_W   = SUM_W - OUT_SHIFT;
    localparam int MPL_W   = (SW > GAIN_W) ? SW : GAIN_W;
    localparam int MC_W    = $clog2(MPL_W);
    localparam int DC_W    = $clog2(DIV_W);

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (OUT_SHIFT - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_PROD  = 9'b000000100,
        ST_ISAT  = 9'b000001000,
        ST_PTERM = 9'b000010000,
        ST_ITERM = 9'b000100000,
        ST_DWAIT = 9'b001000000,
        ST_DTERM = 9'b010000000,
        ST_ROUND = 9'b100000000
    } state_t;

    // Control and state registers (reset)
    state_t                    state_reg, state_next;
    logic signed [GAIN_W-1:0]  gain_p_reg, gain_p_next;
    logic signed [GAIN_W-1:0]  gain_i_reg, gain_i_next;
    logic signed [GAIN_W-1:0]  gain_d_reg, gain_d_next;
    logic signed [CFG_DATA_W-1:0] target_reg, target_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [AW-1:0]      acc_reg, acc_next;
    logic                      div_busy_reg, div_busy_next;
    logic                      out_valid_reg, out_valid_next;

    // Datapath registers (no reset)
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic        [SW-1:0]      dt_reg, dt_next;
    logic                      zero_reg, zero_next;
    logic                      diff_neg_reg, diff_neg_next;
    logic signed [AW-1:0]      acc_new_reg, acc_new_next;
    logic                      clip_reg, clip_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SUM_W-1:0]   mcand_reg, mcand_next;
    logic        [MPL_W-1:0]   mplier_reg, mplier_next;
    logic        [MC_W-1:0]    mac_cnt_reg, mac_cnt_next;
    logic                      mac_signed_reg, mac_signed_next;
    logic        [DC_W-1:0]    div_cnt_reg, div_cnt_next;
    logic        [SW-1:0]      div_rem_reg, div_rem_next;
    logic        [DIV_W-1:0]   div_q_reg, div_q_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic                      clipped_reg, clipped_next;
    logic                      zero_out_reg, zero_out_next;

    // Combinational helpers
    logic                      sample_beat;
    logic                      result_beat;
    logic                      cfg_beat;
    logic signed [SW-1:0]      target_s;
    logic signed [DIFF_W-1:0]  diff;
    logic        [DIFF_W-1:0]  mag;
    logic signed [SUM_W-1:0]   mac_add;
    logic signed [SUM_W-1:0]   mac_sum;
    logic                      mac_last;
    logic        [SW:0]        div_shift;
    logic                      div_ge;
    logic        [SW:0]        div_sub;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ADD_W-1:0]   acc_sum;
    logic                      acc_ovf_pos;
    logic                      acc_ovf_neg;
    logic signed [DERIV_W-1:0] deriv_mag;
    logic signed [DERIV_W-1:0] deriv;
    logic signed [SUM_W-1:0]   sum_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic                      out_ovf_pos;
    logic                      out_ovf_neg;

    assign sample_beat = sample.valid && sample.ready;
    assign result_beat = result.valid && result.ready;
    assign cfg_beat    = cfg.valid && cfg.ready;

    assign sample.ready     = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.drive     = drive_reg;
    assign result.clipped   = clipped_reg;
    assign result.zero_step = zero_out_reg;

    assign target_s = SW'(target_reg);

    // Error difference for the derivative
    assign diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Shift-add step: one multiplier bit per cycle, MSB of a signed gain weighs negative
    assign mac_last = (mac_cnt_reg == '0);
    assign mac_add  = mplier_reg[0] ? mcand_reg : '0;
    assign mac_sum  = (mac_signed_reg && mac_last) ? (sum_reg - mac_add)
                                                   : (sum_reg + mac_add);

    // Restoring divider step: one quotient bit per cycle
    assign div_shift = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, dt_reg});
    assign div_sub   = div_shift - {1'b0, dt_reg};

    // Integral update with saturation
    assign prod        = signed'(sum_reg[PROD_W-1:0]);
    assign acc_sum     = ADD_W'(acc_reg) + ADD_W'(prod);
    assign acc_ovf_pos = !acc_sum[ADD_W-1] && (|acc_sum[ADD_W-2:AW-1]);
    assign acc_ovf_neg = acc_sum[ADD_W-1] && !(&acc_sum[ADD_W-2:AW-1]);

    // Signed derivative from quotient magnitude
    assign deriv_mag = signed'({1'b0, div_q_reg});
    assign deriv     = diff_neg_reg ? -deriv_mag : deriv_mag;

    // Round half up to Q16.16 and check the drive range
    assign sum_rnd     = sum_reg + RND_HALF;
    assign rnd         = sum_rnd[SUM_W-1:OUT_SHIFT];
    assign out_ovf_pos = !rnd[RND_W-1] && (|rnd[RND_W-2:DRIVE_W-1]);
    assign out_ovf_neg = rnd[RND_W-1] && !(&rnd[RND_W-2:DRIVE_W-1]);

    always_comb
    begin
        state_next      = state_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        target_next     = target_reg;
        last_err_next   = last_err_reg;
        acc_next        = acc_reg;
        div_busy_next   = div_busy_reg;
        out_valid_next  = out_valid_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        zero_next       = zero_reg;
        diff_neg_next   = diff_neg_reg;
        acc_new_next    = acc_new_reg;
        clip_next       = clip_reg;
        sum_next        = sum_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        mac_cnt_next    = mac_cnt_reg;
        mac_signed_next = mac_signed_reg;
        div_cnt_next    = div_cnt_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        drive_next      = drive_reg;
        clipped_next    = clipped_reg;
        zero_out_next   = zero_out_reg;

        // Configuration writes; unknown indexes are dropped
        if (cfg_beat)
        begin
            unique case (cfg.index)
                REG_GAIN_P: gain_p_next = signed'(cfg.data);
                REG_GAIN_I: gain_i_next = signed'(cfg.data);
                REG_GAIN_D: gain_d_next = signed'(cfg.data);
                REG_TARGET: target_next = signed'(cfg.data);
                default:    ;
            endcase
        end

        if (result_beat)
        begin
            out_valid_next = 1'b0;
        end

        // Divider runs on its own once started
        if (div_busy_reg)
        begin
            div_rem_next = div_ge ? div_sub[SW-1:0] : div_shift[SW-1:0];
            div_q_next   = {div_q_reg[DIV_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg - 1'b1;
            if (div_cnt_reg == '0)
            begin
                div_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_beat)
                begin
                    err_next   = ERR_W'(target_s) - ERR_W'(sample.measured);
                    dt_next    = sample.step_time;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                zero_next     = (dt_reg == '0);
                diff_neg_next = diff[DIFF_W-1];
                clip_next     = 1'b0;
                // Start the divider on (|diff| << 20) / step_time
                div_busy_next = (dt_reg != '0);
                div_rem_next  = '0;
                div_cnt_next  = DC_W'(DIV_W - 1);
                div_q_next    = (dt_reg == '0) ? '0 : {mag, {DERIV_SHIFT{1'b0}}};
                // error * step_time, step_time unsigned
                sum_next        = '0;
                mcand_next      = SUM_W'(err_reg);
                mplier_next     = MPL_W'(dt_reg);
                mac_cnt_next    = MC_W'(SW - 1);
                mac_signed_next = 1'b0;
                state_next      = ST_PROD;
            end

            ST_PROD:
            begin
                sum_next     = mac_sum;
                mcand_next   = mcand_reg <<< 1;
                mplier_next  = mplier_reg >> 1;
                mac_cnt_next = mac_cnt_reg - 1'b1;
                if (mac_last)
                begin
                    state_next = ST_ISAT;
                end
            end

            ST_ISAT:
            begin
                if (acc_ovf_pos)
                begin
                    acc_new_next = {1'b0, {(AW-1){1'b1}}};
                end
                else if (acc_ovf_neg)
                begin
                    acc_new_next = {1'b1, {(AW-1){1'b0}}};
                end
                else
                begin
                    acc_new_next = acc_sum[AW-1:0];
                end
                clip_next       = acc_ovf_pos || acc_ovf_neg;
                sum_next        = '0;
                mcand_next      = SUM_W'(err_reg) <<< P_SHIFT;
                mplier_next     = MPL_W'(gain_p_reg);
                mac_cnt_next    = MC_W'(GAIN_W - 1);
                mac_signed_next = 1'b1;
                state_next      = ST_PTERM;
            end

            ST_PTERM:
            begin
                sum_next     = mac_sum;
                mcand_next   = mcand_reg <<< 1;
                mplier_next  = mplier_reg >> 1;
                mac_cnt_next = mac_cnt_reg - 1'b1;
                if (mac_last)
                begin
                    mcand_next   = SUM_W'(acc_new_reg);
                    mplier_next  = MPL_W'(gain_i_reg);
                    mac_cnt_next = MC_W'(GAIN_W - 1);
                    state_next   = ST_ITERM;
                end
            end

            ST_ITERM:
            begin
                sum_next     = mac_sum;
                mcand_next   = mcand_reg <<< 1;
                mplier_next  = mplier_reg >> 1;
                mac_cnt_next = mac_cnt_reg - 1'b1;
                if (mac_last)
                begin
                    state_next = ST_DWAIT;
                end
            end

            ST_DWAIT:
            begin
                if (!div_busy_reg)
                begin
                    mcand_next   = SUM_W'(deriv) <<< D_SHIFT;
                    mplier_next  = MPL_W'(gain_d_reg);
                    mac_cnt_next = MC_W'(GAIN_W - 1);
                    state_next   = ST_DTERM;
                end
            end

            ST_DTERM:
            begin
                sum_next     = mac_sum;
                mcand_next   = mcand_reg <<< 1;
                mplier_next  = mplier_reg >> 1;
                mac_cnt_next = mac_cnt_reg - 1'b1;
                if (mac_last)
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    if (out_ovf_pos)
                    begin
                        drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
                    end
                    else if (out_ovf_neg)
                    begin
                        drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
                    end
                    else
                    begin
                        drive_next = rnd[DRIVE_W-1:0];
                    end
                    clipped_next   = clip_reg || out_ovf_pos || out_ovf_neg;
                    zero_out_next  = zero_reg;
                    out_valid_next = 1'b1;
                    acc_next       = acc_new_reg;
                    last_err_next  = err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            target_reg    <= TARGET_RST;
            last_err_reg  <= '0;
            acc_reg       <= '0;
            div_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            target_reg    <= target_next;
            last_err_reg  <= last_err_next;
            acc_reg       <= acc_next;
            div_busy_reg  <= div_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        dt_reg         <= dt_next;
        zero_reg       <= zero_next;
        diff_neg_reg   <= diff_neg_next;
        acc_new_reg    <= acc_new_next;
        clip_reg       <= clip_next;
        sum_reg        <= sum_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        mac_cnt_reg    <= mac_cnt_next;
        mac_signed_reg <= mac_signed_next;
        div_cnt_reg    <= div_cnt_next;
        div_rem_reg    <= div_rem_next;
        div_q_reg      <= div_q_next;
        drive_reg      <= drive_next;
        clipped_reg    <= clipped_next;
        zero_out_reg   <= zero_out_next;
    end

endmodule

[test/tb.sv]
// Testbench for pid_controller_variable_dt: random and directed samples checked by a scoreboard.
`timescale 1ns / 100ps

module tb;
    import pidv_pkg::*;

    // Run control
    localparam int STALL_LIMIT  = 3000;  // cycles with no beat on any channel
    localparam int HOLD_AT      = 1300;  // result count at which the sink holds off
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LO     = 700;   // beats in [QUIET_LO, QUIET_HI) see no idling
    localparam int QUIET_HI     = 1000;
    localparam int DRAIN_CYCLES = 80;    // a bit more than one sample period

    // Saturation limits of the integral (40 bits) and of the drive (32 bits)
    localparam longint INTEG_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint DRIVE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clipped;
        logic                      zero_step;
    } pid_out_t;

    // How a run of samples is shaped
    typedef enum {MIX, WIND_UP, WIND_DOWN, TRACK} stim_kind_t;

    // PID step predictor plus the queue of drive values still owed by the block
    class pid_scoreboard;
        logic signed [GAIN_W-1:0]     gain_p;
        logic signed [GAIN_W-1:0]     gain_i;
        logic signed [GAIN_W-1:0]     gain_d;
        logic signed [CFG_DATA_W-1:0] setpoint;
        longint                       last_err;
        longint                       integral;
        pid_out_t                     owed_q[$];
        int                           errors;

        function new();
            gain_p   = GAIN_P_RST;
            gain_i   = GAIN_I_RST;
            gain_d   = GAIN_D_RST;
            setpoint = TARGET_RST;
            last_err = 0;
            integral = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P: gain_p = data;
                REG_GAIN_I: gain_i = data;
                REG_GAIN_D: gain_d = data;
                REG_TARGET: setpoint = data;
                default: ;  // unmapped index, dropped
            endcase
        endfunction

        function void note_sample(logic signed [15:0] meas, logic [15:0] dt);
            longint          kp, ki, kd, err, prod, acc, diff, deriv, sum, y;
            longint unsigned mag, quo;
            pid_out_t        want;

            kp   = gain_p;
            ki   = gain_i;
            kd   = gain_d;
            err  = longint'(setpoint) - longint'(meas);
            prod = err * longint'(dt);
            acc  = integral;
            want.clipped   = 1'b0;
            want.zero_step = (dt == 16'd0);

            // saturating integral
            if (prod > 0 && acc > INTEG_MAX - prod)
            begin
                acc = INTEG_MAX;
                want.clipped = 1'b1;
            end
            else if (prod < 0 && acc < INTEG_MIN - prod)
            begin
                acc = INTEG_MIN;
                want.clipped = 1'b1;
            end
            else
            begin
                acc = acc + prod;
            end

            // derivative, quotient truncated toward zero; zero step gives 0
            deriv = 0;
            if (!want.zero_step)
            begin
                diff  = err - last_err;
                mag   = (diff < 0) ? -diff : diff;
                quo   = (mag << DERIV_SHIFT) / dt;
                deriv = (diff < 0) ? -longint'(quo) : longint'(quo);
            end

            sum = ((kp * err) <<< P_SHIFT) + ki * acc + ((kd * deriv) <<< D_SHIFT);
            y   = (sum + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            if (y > DRIVE_MAX)
            begin
                y = DRIVE_MAX;
                want.clipped = 1'b1;
            end
            else if (y < DRIVE_MIN)
            begin
                y = DRIVE_MIN;
                want.clipped = 1'b1;
            end
            want.drive = y[31:0];

            integral = acc;
            last_err = err;
            owed_q.push_back(want);
        endfunction

        function void check_result(logic signed [DRIVE_W-1:0] drive, logic clipped,
                                   logic zero_step);
            pid_out_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing owed: drive %0d", $time, drive);
                return;
            end
            want = owed_q.pop_front();
            if (drive !== want.drive)
            begin
                errors++;
                $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive);
            end
            if (clipped !== want.clipped)
            begin
                errors++;
                $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, clipped);
            end
            if (zero_step !== want.zero_step)
            begin
                errors++;
                $display("%0t: zero_step expected %0b actual %0b", $time,
                         want.zero_step, zero_step);
            end
        endfunction

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pidv_sample_if #(.SAMPLE_WIDTH(16)) smp_if ();
    pidv_result_if                      res_if ();
    pidv_cfg_if                         cfg_if ();

    pid_controller_variable_dt #(
        .SAMPLE_WIDTH (16),
        .ACCUM_WIDTH  (40)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    pid_scoreboard sb = new();
    int            sent = 0;    // sample beats accepted so far
    int            quiet_cnt = 0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Field generators
    // ------------------------------------------------------------------

    // Measurement: extremes, values around zero, or anything
    function automatic logic signed [15:0] any_measured();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Step: zero, one, full scale, tiny (huge derivative), or anything
    function automatic logic [15:0] any_step();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(64, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly moderate gains, sometimes the full range
    function automatic logic [15:0] rand_gain();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(8192)) - 16'd4096;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one sample and hold it until taken. Valid stays high afterwards
    // unless this is the last beat of a run or an idle gap follows.
    task automatic offer(input logic signed [15:0] meas, input logic [15:0] dt,
                         input bit last);
        smp_if.valid     <= 1'b1;
        smp_if.measured  <= meas;
        smp_if.step_time <= dt;
        do @(posedge clk); while (!smp_if.ready);
        sb.note_sample(meas, dt);
        sent++;
        if (last)
        begin
            smp_if.valid <= 1'b0;
        end
        else if (!(sent >= QUIET_LO && sent < QUIET_HI) && $urandom_range(99) < 30)
        begin
            // gap of random length so it lands on any phase of the datapath
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(100, 1)) @(posedge clk);
        end
    endtask

    // One register beat; valid is left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, data);
    endtask

    // Block is idle once every owed result has come back (one result per sample)
    task automatic wait_idle();
        while (sb.owed() != 0) @(posedge clk);
    endtask

    task automatic send_run(input stim_kind_t kind, input int count);
        int                 v;
        logic signed [15:0] meas;
        logic        [15:0] dt;
        for (int n = 0; n < count; n++)
        begin
            meas = any_measured();
            dt   = any_step();
            case (kind)
                // steady max error of one sign drives the integral into its rail;
                // one beat in ten is noise
                WIND_UP:
                begin
                    if ($urandom_range(9) != 0)
                    begin
                        meas = 16'sh8000 + 16'($urandom_range(767));
                        dt   = 16'($urandom_range(65535, 60000));
                    end
                end
                WIND_DOWN:
                begin
                    if ($urandom_range(9) != 0)
                    begin
                        meas = 16'sh7FFF - 16'($urandom_range(767));
                        dt   = 16'($urandom_range(65535, 60000));
                    end
                end
                // closed-loop look: measurement near the setpoint, step near 1.0
                TRACK:
                begin
                    if ($urandom_range(7) != 0)
                    begin
                        v = int'(sb.setpoint) + int'($urandom_range(1200)) - 600;
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                        meas = 16'(v);
                        dt   = ($urandom_range(15) == 0) ? 16'd0
                                                         : 16'd3584 + 16'($urandom_range(1024));
                    end
                end
                default: ;
            endcase
            offer(meas, dt, n == count - 1);
        end
    endtask

    // New settings on an idle block, then a run of samples. The integral and
    // last error carry over; only reset clears them.
    task automatic run_phase(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] tgt,
                             input stim_kind_t kind, input int count);
        wait_idle();
        // unmapped index with junk data must not disturb anything
        write_reg(REG_TARGET + 4'd1 + 4'($urandom_range(15 - REG_TARGET - 1)), 16'($urandom));
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_TARGET, tgt);
        cfg_if.valid <= 1'b0;
        send_run(kind, count);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, one long hold-off, one stall-free stretch
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int taken;
        bit held;
        stall_left = 0;
        taken      = 0;
        held       = 1'b0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                taken++;
            if (!held && taken == HOLD_AT)
            begin
                // sender keeps offering; both slots fill and sample.ready drops
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (taken >= QUIET_LO && taken < QUIET_HI)
            begin
                res_if.ready <= 1'b1;
            end
            else if ($urandom_range(99) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(20, 1) - 1;
            end
            else
            begin
                res_if.ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
        if (res_if.valid && res_if.ready)
            sb.check_result(res_if.drive, res_if.clipped, res_if.zero_step);

    // Watchdog: too long with no beat on any channel ends the run
    always @(posedge clk)
    begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] dir_meas [16];
        logic [15:0] dir_step [16];

        // directed samples at reset settings: zero step first (derivative off
        // a zero last error), full-scale error both ways, step of one (huge
        // derivative, drive rails), zero error, further zero steps among them
        dir_meas = '{16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h0A00, 16'h0A00, 16'h0000, 16'hFFFF, 16'h8000, 16'h0100,
                     16'h7FFF, 16'h8000, 16'h0000, 16'h03E8};
        dir_step = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001,
                     16'h1000, 16'h0000, 16'h1000, 16'h0001, 16'h0000, 16'h8000,
                     16'h0002, 16'h0002, 16'hFFFF, 16'h3039};

        rst_n            <= 1'b0;
        smp_if.valid     <= 1'b0;
        smp_if.measured  <= '0;
        smp_if.step_time <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 16; k++)
            offer(dir_meas[k], dir_step[k], k == 15);

        // integral wound to the upper rail, then all the way to the lower one;
        // integral gain of 1 so the drive follows the integral, scaled by 2^-16
        run_phase(16'd0, 16'd1, 16'd0, 16'h7FFF, WIND_UP, 280);
        run_phase(16'd0, 16'd1, 16'd0, 16'h8000, WIND_DOWN, 300);
        // register extremes
        run_phase(16'h8000, 16'h8000, 16'h8000, 16'h8000, MIX, 120);
        run_phase(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, MIX, 120);
        run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, MIX, 80);
        for (int p = 0; p < 7; p++)
            run_phase(rand_gain(), rand_gain(), rand_gain(), 16'($urandom),
                      (p % 2) ? TRACK : MIX, 120);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[pid_controller_variable_dt.f]
src/pidv_pkg.sv
src/pidv_sample_if.sv
src/pidv_result_if.sv
src/pidv_cfg_if.sv
src/pid_controller_variable_dt.sv
test/tb.sv
